/* rtl/tlboa_pkg.sv */
// Shared types and codes of the two-level bin offset allocator.
`timescale 1ns / 1ps
package tlboa_pkg;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_SPACE   = 2'd1,
      STAT_BAD_HANDLE = 2'd2
   } status_type;

   localparam int          MANT_BITS  = 3;
   localparam int          NUM_BINS   = 256;
   localparam int          NUM_TOP    = 32;
   localparam logic [31:0] HEAP_RESET = 32'd65536;

   typedef struct packed {
      func_type    func;
      logic [31:0] request_size;
      logic [10:0] release_handle;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] block_offset;
      logic [10:0] block_handle;
      logic [31:0] free_total;
      logic [31:0] largest_free;
   } rsp_type;

endpackage

/* rtl/tlboa_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module tlboa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/two_level_bin_offset_allocator.sv */
// Top level of the two-level bin offset allocator.
// Usage:
//   req_valid/req_ready/req_data: one command per transfer (allocate, free,
//   restart). rsp_valid/rsp_ready/rsp_data: exactly one result per command,
//   in order. csr_we/csr_wdata: heap size, used at the next restart.
// Structure: commands run one at a time through a sequencer around a node RAM
//   and an auxiliary RAM (spare stack and bin heads), each with one read and
//   one write port and a registered read. A free adds an unlink for each merged
//   neighbor, and every command is paced by its dependent node RAM accesses.
// Reset: the block builds the heap of 65536 bytes as one free region, with
//   req_ready low meanwhile; the RAMs are never cleared.
// Stall: the result sits in an output register, and the next command is
//   taken while it waits; the block holds a finished result until rsp_ready.
`timescale 1ns / 1ps
module two_level_bin_offset_allocator #(
   parameter int MAX_ALLOCS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlboa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlboa_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);

   localparam int NODES = MAX_ALLOCS + 1;
   localparam int IW    = $clog2(NODES + 1);
   localparam int ADEP  = NODES + tlboa_pkg::NUM_BINS;
   localparam int AW    = $clog2(ADEP);
   localparam int NAW   = $clog2(NODES);
   localparam logic [IW-1:0] NONE = '1;

   typedef struct packed {
      logic [31:0]   offset;
      logic [31:0]   size;
      logic          in_use;
      logic [IW-1:0] bin_next;
      logic [IW-1:0] bin_prev;
      logic [IW-1:0] addr_next;
      logic [IW-1:0] addr_prev;
   } node_type;

   typedef enum logic [5:0] {
      S_IDLE, S_RS,
      S_I0, S_I1, S_I2, S_I3, S_I4, S_I5,
      S_R0, S_R1, S_R3, S_R4, S_R5, S_R6,
      S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9, S_A10,
      S_A11, S_A12,
      S_F0, S_F1, S_F2, S_F4, S_F5, S_F7, S_F8, S_F9, S_F10, S_F11, S_F12,
      S_RPT0, S_RPT1
   } state_type;

   function automatic logic [4:0] high_bit(input logic [31:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 1; i < 32; i++) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

   function automatic logic [4:0] low_bit32(input logic [31:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

   function automatic logic [2:0] low_bit8(input logic [7:0] v);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) r = 3'(i);
      end
      return r;
   endfunction

   function automatic logic [7:0] class_up(input logic [31:0] size, input logic [4:0] hb);
      logic [4:0]  s;
      logic [3:0]  m;
      logic [31:0] low;
      logic [7:0]  r;
      s   = hb - 5'd3;
      m   = {1'b0, 3'(size >> s)};
      low = (32'd1 << s) - 32'd1;
      if ((size & low) != 32'd0) m = m + 4'd1;
      r = {s + 5'd1, 3'b000} + {4'b0000, m};
      if (size < 32'd8) r = size[7:0];
      return r;
   endfunction

   function automatic logic [7:0] class_down(input logic [31:0] size, input logic [4:0] hb);
      logic [4:0] s;
      logic [7:0] r;
      s = hb - 5'd3;
      r = {s + 5'd1, 3'(size >> s)};
      if (size < 32'd8) r = size[7:0];
      return r;
   endfunction

   function automatic logic [31:0] class_value(input logic [7:0] f);
      logic [31:0] r;
      if (f[7:3] == 5'd0) begin
         r = {29'd0, f[2:0]};
      end else begin
         r = {28'd0, 1'b1, f[2:0]} << (f[7:3] - 5'd1);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] bin_addr(input logic [7:0] b);
      return AW'(NODES) + AW'(b);
   endfunction

   function automatic logic node_ok(input logic [IW-1:0] x);
      return x < IW'(NODES);
   endfunction

   // A node holds live data only once it has left the untouched part of the stack.
   function automatic logic in_use_eff(input logic [IW-1:0] x, input logic mark,
                                       input logic [IW-1:0] mintop);
      return ((IW'(MAX_ALLOCS) - x) > mintop) && mark;
   endfunction

   state_type             state_ff, state_in, ins_ret_ff, ins_ret_in, rm_ret_ff, rm_ret_in;
   logic [31:0]           heap_size_ff, heap_size_in;
   logic [255:0]          occ_ff, occ_in;
   logic [31:0]           free_ff, free_in;
   logic [IW-1:0]         top_ff, top_in, mintop_ff, mintop_in;
   tlboa_pkg::func_type   func_ff, func_in;
   logic [31:0]           req_sz_ff, req_sz_in;
   logic [IW-1:0]         h_ff, h_in;
   logic                  hbad_ff, hbad_in;
   logic [4:0]            hb_ff, hb_in;
   logic [7:0]            mb_ff, mb_in, b_ff, b_in;
   logic [31:0]           tv_ff, tv_in;
   logic                  tnz_ff, tnz_in;
   logic [IW-1:0]         n_ff, n_in, x_ff, x_in, an_ff, an_in, ap_ff, ap_in;
   logic [31:0]           tot_ff, tot_in, aoff_ff, aoff_in, asz_ff, asz_in;
   logic [31:0]           ins_sz_ff, ins_sz_in, ins_off_ff, ins_off_in;
   logic [IW-1:0]         head_ff, head_in, m_ff, m_in;
   logic [IW-1:0]         rm_n_ff, rm_n_in, rm_bp_ff, rm_bp_in, rm_bn_ff, rm_bn_in;
   logic [31:0]           rm_sz_ff, rm_sz_in;
   tlboa_pkg::status_type status_ff, status_in;
   logic [31:0]           blk_off_ff, blk_off_in;
   logic [IW-1:0]         blk_h_ff, blk_h_in;
   tlboa_pkg::rsp_type    rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  nd_we;
   logic [NAW-1:0]        nd_waddr, nd_raddr;
   node_type              nd_wdata, nd_rdata;
   logic                  ax_we;
   logic [AW-1:0]         ax_waddr, ax_raddr;
   logic [IW-1:0]         ax_wdata, ax_rdata;

   tlboa_ram #(.WIDTH($bits(node_type)), .DEPTH(NODES)) u_node_ram (
      .clock  (clock),
      .wr_en  (nd_we),
      .wr_addr(nd_waddr),
      .wr_data(nd_wdata),
      .rd_addr(nd_raddr),
      .rd_data(nd_rdata)
   );

   // Spare stack at the low addresses, bin heads above it.
   tlboa_ram #(.WIDTH(IW), .DEPTH(ADEP)) u_aux_ram (
      .clock  (clock),
      .wr_en  (ax_we),
      .wr_addr(ax_waddr),
      .wr_data(ax_wdata),
      .rd_addr(ax_raddr),
      .rd_data(ax_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      node_type      rec;
      logic [IW-1:0] pop_n;
      logic [IW-1:0] top_inc;
      logic [7:0]    bsel;
      logic [4:0]    tsel;
      logic [7:0]    lmask;
      logic [31:0]   tany;
      logic [31:0]   rem;

      state_in     = state_ff;
      ins_ret_in   = ins_ret_ff;
      rm_ret_in    = rm_ret_ff;
      heap_size_in = csr_we ? csr_wdata : heap_size_ff;
      occ_in       = occ_ff;
      free_in      = free_ff;
      top_in       = top_ff;
      mintop_in    = mintop_ff;
      func_in      = func_ff;
      req_sz_in    = req_sz_ff;
      h_in         = h_ff;
      hbad_in      = hbad_ff;
      hb_in        = hb_ff;
      mb_in        = mb_ff;
      b_in         = b_ff;
      tv_in        = tv_ff;
      tnz_in       = tnz_ff;
      n_in         = n_ff;
      x_in         = x_ff;
      an_in        = an_ff;
      ap_in        = ap_ff;
      tot_in       = tot_ff;
      aoff_in      = aoff_ff;
      asz_in       = asz_ff;
      ins_sz_in    = ins_sz_ff;
      ins_off_in   = ins_off_ff;
      head_in      = head_ff;
      m_in         = m_ff;
      rm_n_in      = rm_n_ff;
      rm_bp_in     = rm_bp_ff;
      rm_bn_in     = rm_bn_ff;
      rm_sz_in     = rm_sz_ff;
      status_in    = status_ff;
      blk_off_in   = blk_off_ff;
      blk_h_in     = blk_h_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      nd_we    = 1'b0;
      nd_waddr = NAW'(n_ff);
      nd_wdata = nd_rdata;
      nd_raddr = '0;
      ax_we    = 1'b0;
      ax_waddr = '0;
      ax_wdata = '0;
      ax_raddr = '0;

      rec     = nd_rdata;
      pop_n   = '0;
      top_inc = top_ff + IW'(1);
      bsel    = '0;
      tsel    = '0;
      lmask   = '0;
      tany    = '0;
      rem     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in    = req_data.func;
               req_sz_in  = req_data.request_size;
               h_in       = IW'(req_data.release_handle);
               hbad_in    = 32'(req_data.release_handle) > 32'(MAX_ALLOCS);
               status_in  = tlboa_pkg::STAT_OK;
               blk_off_in = '0;
               blk_h_in   = '0;
               unique case (req_data.func)
                  tlboa_pkg::FUNC_ALLOC:   state_in = S_A0;
                  tlboa_pkg::FUNC_FREE:    state_in = S_F0;
                  tlboa_pkg::FUNC_RESTART: state_in = S_RS;
                  default:                 state_in = S_RPT0;
               endcase
            end
         end

         S_RS: begin
            top_in     = IW'(MAX_ALLOCS);
            mintop_in  = IW'(MAX_ALLOCS);
            occ_in     = '0;
            free_in    = '0;
            ins_sz_in  = heap_size_ff;
            ins_off_in = '0;
            ins_ret_in = S_RPT0;
            state_in   = S_I0;
         end

         // insert a free region of ins_sz at ins_off; new node in m
         S_I0: begin
            hb_in    = high_bit(ins_sz_ff);
            state_in = S_I1;
         end
         S_I1: begin
            bsel     = class_down(ins_sz_ff, hb_ff);
            b_in     = bsel;
            ax_raddr = bin_addr(bsel);
            state_in = S_I2;
         end
         S_I2: begin
            head_in        = occ_ff[b_ff] ? ax_rdata : NONE;
            occ_in[b_ff]   = 1'b1;
            ax_raddr       = AW'(top_ff);
            state_in       = S_I3;
         end
         S_I3: begin
            pop_n    = (top_ff > mintop_ff) ? ax_rdata : IW'(MAX_ALLOCS) - top_ff;
            m_in     = pop_n;
            top_in   = top_ff - IW'(1);
            if ((top_ff - IW'(1)) < mintop_ff) mintop_in = top_ff - IW'(1);
            nd_we    = 1'b1;
            nd_waddr = NAW'(pop_n);
            nd_wdata = '{offset: ins_off_ff, size: ins_sz_ff, in_use: 1'b0,
                         bin_next: head_ff, bin_prev: NONE,
                         addr_next: NONE, addr_prev: NONE};
            ax_we    = 1'b1;
            ax_waddr = bin_addr(b_ff);
            ax_wdata = pop_n;
            free_in  = free_ff + ins_sz_ff;
            state_in = node_ok(head_ff) ? S_I4 : ins_ret_ff;
         end
         S_I4: begin
            nd_raddr = NAW'(head_ff);
            state_in = S_I5;
         end
         S_I5: begin
            nd_we             = 1'b1;
            nd_waddr          = NAW'(head_ff);
            nd_wdata          = nd_rdata;
            nd_wdata.bin_prev = m_ff;
            state_in          = ins_ret_ff;
         end

         // unlink free node rm_n from its bin and return it to the spare stack
         S_R0: begin
            hb_in = high_bit(rm_sz_ff);
            if (node_ok(rm_bp_ff)) begin
               nd_raddr = NAW'(rm_bp_ff);
               state_in = S_R1;
            end else begin
               state_in = S_R3;
            end
         end
         S_R1: begin
            nd_we             = 1'b1;
            nd_waddr          = NAW'(rm_bp_ff);
            nd_wdata          = nd_rdata;
            nd_wdata.bin_next = rm_bn_ff;
            state_in          = S_R4;
         end
         S_R3: begin
            bsel     = class_down(rm_sz_ff, hb_ff);
            ax_we    = 1'b1;
            ax_waddr = bin_addr(bsel);
            ax_wdata = rm_bn_ff;
            if (!node_ok(rm_bn_ff)) occ_in[bsel] = 1'b0;
            state_in = S_R4;
         end
         S_R4: begin
            if (node_ok(rm_bn_ff)) begin
               nd_raddr = NAW'(rm_bn_ff);
               state_in = S_R5;
            end else begin
               state_in = S_R6;
            end
         end
         S_R5: begin
            nd_we             = 1'b1;
            nd_waddr          = NAW'(rm_bn_ff);
            nd_wdata          = nd_rdata;
            nd_wdata.bin_prev = rm_bp_ff;
            state_in          = S_R6;
         end
         S_R6: begin
            if (top_inc < IW'(NODES)) begin
               ax_we    = 1'b1;
               ax_waddr = AW'(top_inc);
               ax_wdata = rm_n_ff;
               top_in   = top_inc;
            end
            free_in  = free_ff - rm_sz_ff;
            state_in = rm_ret_ff;
         end

         // allocate
         S_A0: begin
            if (top_ff == '0) begin
               status_in = tlboa_pkg::STAT_NO_SPACE;
               state_in  = S_RPT0;
            end else begin
               hb_in    = high_bit(req_sz_ff);
               state_in = S_A1;
            end
         end
         S_A1: begin
            mb_in    = class_up(req_sz_ff, hb_ff);
            state_in = S_A2;
         end
         S_A2: begin
            for (int t = 0; t < tlboa_pkg::NUM_TOP; t++) begin
               if (5'(t) == mb_ff[7:3]) begin
                  tv_in[t] = |(occ_ff[8*t +: 8] & (8'hFF << mb_ff[2:0]));
               end else begin
                  tv_in[t] = (5'(t) > mb_ff[7:3]) && (|occ_ff[8*t +: 8]);
               end
            end
            state_in = S_A3;
         end
         S_A3: begin
            if (tv_ff == '0) begin
               status_in = tlboa_pkg::STAT_NO_SPACE;
               state_in  = S_RPT0;
            end else begin
               tsel     = low_bit32(tv_ff);
               lmask    = (tsel == mb_ff[7:3]) ? (8'hFF << mb_ff[2:0]) : 8'hFF;
               bsel     = {tsel, low_bit8(occ_ff[{tsel, 3'b000} +: 8] & lmask)};
               b_in     = bsel;
               ax_raddr = bin_addr(bsel);
               state_in = S_A4;
            end
         end
         S_A4: begin
            n_in     = ax_rdata;
            nd_raddr = NAW'(ax_rdata);
            state_in = S_A5;
         end
         S_A5: begin
            tot_in          = rec.size;
            x_in            = rec.bin_next;
            aoff_in         = rec.offset;
            an_in           = rec.addr_next;
            blk_off_in      = rec.offset;
            blk_h_in        = n_ff;
            nd_we           = 1'b1;
            nd_waddr        = NAW'(n_ff);
            nd_wdata        = rec;
            nd_wdata.size   = req_sz_ff;
            nd_wdata.in_use = 1'b1;
            ax_we           = 1'b1;
            ax_waddr        = bin_addr(b_ff);
            ax_wdata        = rec.bin_next;
            if (!node_ok(rec.bin_next)) occ_in[b_ff] = 1'b0;
            free_in         = free_ff - rec.size;
            state_in        = S_A6;
         end
         S_A6: begin
            if (node_ok(x_ff)) begin
               nd_raddr = NAW'(x_ff);
               state_in = S_A7;
            end else begin
               state_in = S_A8;
            end
         end
         S_A7: begin
            nd_we             = 1'b1;
            nd_waddr          = NAW'(x_ff);
            nd_wdata          = nd_rdata;
            nd_wdata.bin_prev = NONE;
            state_in          = S_A8;
         end
         S_A8: begin
            rem = tot_ff - req_sz_ff;
            if (rem != '0) begin
               ins_sz_in  = rem;
               ins_off_in = aoff_ff + req_sz_ff;
               ins_ret_in = S_A9;
               state_in   = S_I0;
            end else begin
               state_in = S_RPT0;
            end
         end
         S_A9: begin
            if (node_ok(an_ff)) begin
               nd_raddr = NAW'(an_ff);
               state_in = S_A10;
            end else begin
               state_in = S_A11;
            end
         end
         S_A10: begin
            nd_we              = 1'b1;
            nd_waddr           = NAW'(an_ff);
            nd_wdata           = nd_rdata;
            nd_wdata.addr_prev = m_ff;
            state_in           = S_A11;
         end
         S_A11: begin
            nd_we    = 1'b1;
            nd_waddr = NAW'(m_ff);
            nd_wdata = '{offset: ins_off_ff, size: ins_sz_ff, in_use: 1'b0,
                         bin_next: head_ff, bin_prev: NONE,
                         addr_next: an_ff, addr_prev: n_ff};
            nd_raddr = NAW'(n_ff);
            state_in = S_A12;
         end
         S_A12: begin
            nd_we              = 1'b1;
            nd_waddr           = NAW'(n_ff);
            nd_wdata           = nd_rdata;
            nd_wdata.addr_next = m_ff;
            state_in           = S_RPT0;
         end

         // free, merging with free address neighbors
         S_F0: begin
            if (hbad_ff) begin
               status_in = tlboa_pkg::STAT_BAD_HANDLE;
               state_in  = S_RPT0;
            end else begin
               nd_raddr = NAW'(h_ff);
               state_in = S_F1;
            end
         end
         S_F1: begin
            if (!in_use_eff(h_ff, rec.in_use, mintop_ff)) begin
               status_in = tlboa_pkg::STAT_BAD_HANDLE;
               state_in  = S_RPT0;
            end else begin
               aoff_in = rec.offset;
               asz_in  = rec.size;
               an_in   = rec.addr_next;
               ap_in   = rec.addr_prev;
               if (node_ok(rec.addr_prev)) begin
                  nd_raddr = NAW'(rec.addr_prev);
                  state_in = S_F2;
               end else begin
                  state_in = S_F4;
               end
            end
         end
         S_F2: begin
            if (!in_use_eff(ap_ff, rec.in_use, mintop_ff)) begin
               aoff_in   = rec.offset;
               asz_in    = asz_ff + rec.size;
               ap_in     = rec.addr_prev;
               rm_n_in   = ap_ff;
               rm_bp_in  = rec.bin_prev;
               rm_bn_in  = rec.bin_next;
               rm_sz_in  = rec.size;
               rm_ret_in = S_F4;
               state_in  = S_R0;
            end else begin
               state_in = S_F4;
            end
         end
         S_F4: begin
            if (node_ok(an_ff)) begin
               nd_raddr = NAW'(an_ff);
               state_in = S_F5;
            end else begin
               state_in = S_F7;
            end
         end
         S_F5: begin
            if (!in_use_eff(an_ff, rec.in_use, mintop_ff)) begin
               asz_in    = asz_ff + rec.size;
               an_in     = rec.addr_next;
               rm_n_in   = an_ff;
               rm_bp_in  = rec.bin_prev;
               rm_bn_in  = rec.bin_next;
               rm_sz_in  = rec.size;
               rm_ret_in = S_F7;
               state_in  = S_R0;
            end else begin
               state_in = S_F7;
            end
         end
         S_F7: begin
            if (top_inc < IW'(NODES)) begin
               ax_we    = 1'b1;
               ax_waddr = AW'(top_inc);
               ax_wdata = h_ff;
               top_in   = top_inc;
            end
            ins_sz_in  = asz_ff;
            ins_off_in = aoff_ff;
            ins_ret_in = S_F8;
            state_in   = S_I0;
         end
         S_F8: begin
            nd_we    = 1'b1;
            nd_waddr = NAW'(m_ff);
            nd_wdata = '{offset: aoff_ff, size: asz_ff, in_use: 1'b0,
                         bin_next: head_ff, bin_prev: NONE,
                         addr_next: an_ff, addr_prev: ap_ff};
            state_in = S_F9;
         end
         S_F9: begin
            if (node_ok(an_ff)) begin
               nd_raddr = NAW'(an_ff);
               state_in = S_F10;
            end else begin
               state_in = S_F11;
            end
         end
         S_F10: begin
            nd_we              = 1'b1;
            nd_waddr           = NAW'(an_ff);
            nd_wdata           = nd_rdata;
            nd_wdata.addr_prev = m_ff;
            state_in           = S_F11;
         end
         S_F11: begin
            if (node_ok(ap_ff)) begin
               nd_raddr = NAW'(ap_ff);
               state_in = S_F12;
            end else begin
               state_in = S_RPT0;
            end
         end
         S_F12: begin
            nd_we              = 1'b1;
            nd_waddr           = NAW'(ap_ff);
            nd_wdata           = nd_rdata;
            nd_wdata.addr_next = m_ff;
            state_in           = S_RPT0;
         end

         // free total and largest occupied bin
         S_RPT0: begin
            for (int t = 0; t < tlboa_pkg::NUM_TOP; t++) begin
               tany[t] = |occ_ff[8*t +: 8];
            end
            hb_in    = high_bit(tany);
            tnz_in   = |tany;
            state_in = S_RPT1;
         end
         S_RPT1: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status       = status_ff;
               rsp_in.block_offset = blk_off_ff;
               rsp_in.block_handle = 11'(blk_h_ff);
               rsp_in.free_total   = (top_ff != '0) ? free_ff : '0;
               rsp_in.largest_free = '0;
               if (top_ff != '0 && tnz_ff) begin
                  rsp_in.largest_free = class_value({hb_ff,
                     high_bit({24'd0, occ_ff[{hb_ff, 3'b000} +: 8]})[2:0]});
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_I0;
         ins_ret_ff   <= S_IDLE;
         rm_ret_ff    <= S_IDLE;
         heap_size_ff <= tlboa_pkg::HEAP_RESET;
         occ_ff       <= '0;
         free_ff      <= '0;
         top_ff       <= IW'(MAX_ALLOCS);
         mintop_ff    <= IW'(MAX_ALLOCS);
         ins_sz_ff    <= tlboa_pkg::HEAP_RESET;
         ins_off_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ins_ret_ff   <= ins_ret_in;
         rm_ret_ff    <= rm_ret_in;
         heap_size_ff <= heap_size_in;
         occ_ff       <= occ_in;
         free_ff      <= free_in;
         top_ff       <= top_in;
         mintop_ff    <= mintop_in;
         ins_sz_ff    <= ins_sz_in;
         ins_off_ff   <= ins_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      req_sz_ff  <= req_sz_in;
      h_ff       <= h_in;
      hbad_ff    <= hbad_in;
      hb_ff      <= hb_in;
      mb_ff      <= mb_in;
      b_ff       <= b_in;
      tv_ff      <= tv_in;
      tnz_ff     <= tnz_in;
      n_ff       <= n_in;
      x_ff       <= x_in;
      an_ff      <= an_in;
      ap_ff      <= ap_in;
      tot_ff     <= tot_in;
      aoff_ff    <= aoff_in;
      asz_ff     <= asz_in;
      head_ff    <= head_in;
      m_ff       <= m_in;
      rm_n_ff    <= rm_n_in;
      rm_bp_ff   <= rm_bp_in;
      rm_bn_ff   <= rm_bn_in;
      rm_sz_ff   <= rm_sz_in;
      status_ff  <= status_in;
      blk_off_ff <= blk_off_in;
      blk_h_ff   <= blk_h_in;
      rsp_ff     <= rsp_in;
   end

endmodule

/* verif/alloc_checker.sv */
// Checker for the two-level bin offset allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module alloc_checker
   import tlboa_pkg::*;
#(
   parameter int MAX_ALLOCS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_we,
   input  logic [31:0] csr_wdata,
   output int      errors,
   output int      pending
);

   localparam int         NODES = MAX_ALLOCS + 1;
   localparam logic [10:0] NONE = 11'h7FF;

   logic [31:0] heap_bytes;
   logic [31:0] node_off [NODES];
   logic [31:0] node_size [NODES];
   bit          node_used [NODES];
   logic [10:0] bin_next [NODES];
   logic [10:0] bin_prev [NODES];
   logic [10:0] addr_next [NODES];
   logic [10:0] addr_prev [NODES];
   logic [10:0] spare [NODES];
   int unsigned spare_top;
   logic [10:0] bin_head [NUM_BINS];
   logic [7:0]  leaf_mask [NUM_TOP];
   logic [31:0] top_mask;
   logic [31:0] free_bytes;

   rsp_type expected_rsps[$];

   assign pending = expected_rsps.size();

   function automatic bit live(logic [10:0] n);
      return int'(n) < NODES;
   endfunction

   function automatic int unsigned msb(logic [31:0] v);
      int unsigned b;
      b = 0;
      while (b < 31 && (v >> (b + 1)) != 0) b++;
      return b;
   endfunction

   function automatic int unsigned first_from(logic [31:0] mask, int unsigned start);
      for (int unsigned b = start; b < 32; b++)
         if (mask[b]) return b;
      return 32;
   endfunction

   function automatic int unsigned class_up(logic [31:0] size);
      int unsigned s, m;
      if (size < 8) return size;
      s = msb(size) - MANT_BITS;
      m = (size >> s) & 7;
      if ((size & ((32'd1 << s) - 1)) != 0) m++;
      return ((s + 1) << MANT_BITS) + m;
   endfunction

   function automatic int unsigned class_down(logic [31:0] size);
      int unsigned s;
      if (size < 8) return size;
      s = msb(size) - MANT_BITS;
      return ((s + 1) << MANT_BITS) | ((size >> s) & 7);
   endfunction

   function automatic logic [31:0] class_bytes(int unsigned f);
      int unsigned e, m;
      e = (f >> MANT_BITS) & 31;
      m = f & 7;
      if (e == 0) return m;
      return (m | 8) << (e - 1);
   endfunction

   function automatic void spare_push(logic [10:0] n);
      if (spare_top + 1 < NODES) begin
         spare_top++;
         spare[spare_top] = n;
      end
   endfunction

   function automatic logic [10:0] spare_pop();
      logic [10:0] n;
      n = spare[spare_top];
      if (spare_top > 0) spare_top--;
      return n;
   endfunction

   function automatic void clear_bin(int unsigned b);
      int unsigned t;
      t = (b >> MANT_BITS) & 31;
      leaf_mask[t][b & 7] = 1'b0;
      if (leaf_mask[t] == 0) top_mask[t] = 1'b0;
   endfunction

   function automatic logic [10:0] bin_insert(logic [31:0] size, logic [31:0] off);
      int unsigned b;
      logic [10:0] head, n;
      b = class_down(size) & 8'hFF;
      head = bin_head[b];
      if (head == NONE) begin
         leaf_mask[b >> MANT_BITS][b & 7] = 1'b1;
         top_mask[b >> MANT_BITS] = 1'b1;
      end
      n = spare_pop();
      if (!live(n)) return NONE;
      node_off[n] = off;
      node_size[n] = size;
      node_used[n] = 1'b0;
      bin_next[n] = head;
      bin_prev[n] = NONE;
      addr_next[n] = NONE;
      addr_prev[n] = NONE;
      if (live(head)) bin_prev[head] = n;
      bin_head[b] = n;
      free_bytes += size;
      return n;
   endfunction

   function automatic void bin_remove(logic [10:0] n);
      logic [10:0] p, x;
      int unsigned b;
      p = bin_prev[n];
      x = bin_next[n];
      if (p != NONE) begin
         if (live(p)) bin_next[p] = x;
         if (live(x)) bin_prev[x] = p;
      end else begin
         b = class_down(node_size[n]) & 8'hFF;
         bin_head[b] = x;
         if (live(x)) bin_prev[x] = NONE;
         if (x == NONE) clear_bin(b);
      end
      spare_push(n);
      free_bytes -= node_size[n];
   endfunction

   function automatic void rebuild();
      logic [10:0] n;
      for (int i = 0; i < NODES; i++) begin
         node_off[i] = '0;
         node_size[i] = '0;
         node_used[i] = 1'b0;
         bin_next[i] = NONE;
         bin_prev[i] = NONE;
         addr_next[i] = NONE;
         addr_prev[i] = NONE;
         spare[i] = 11'(MAX_ALLOCS - i);
      end
      for (int i = 0; i < NUM_BINS; i++) bin_head[i] = NONE;
      for (int i = 0; i < NUM_TOP; i++) leaf_mask[i] = '0;
      top_mask = '0;
      free_bytes = '0;
      spare_top = MAX_ALLOCS;
      n = bin_insert(heap_bytes, 32'd0);
   endfunction

   function automatic status_type do_alloc(logic [31:0] want, output logic [31:0] off,
                                           output logic [10:0] handle);
      int unsigned mb, mt, ml, t, l, b;
      logic [10:0] n, x, m, nx;
      logic [31:0] total, rem;
      off = '0;
      handle = '0;
      l = 32;
      if (spare_top == 0) return STAT_NO_SPACE;
      mb = class_up(want);
      mt = mb >> MANT_BITS;
      ml = mb & 7;
      t = mt;
      if (t < 32 && top_mask[t]) l = first_from(32'(leaf_mask[t]), ml);
      if (l == 32) begin
         t = first_from(top_mask, mt + 1);
         if (t == 32) return STAT_NO_SPACE;
         l = first_from(32'(leaf_mask[t]), 0);
         if (l >= 8) return STAT_NO_SPACE;
      end
      b = (t << MANT_BITS) | l;
      n = bin_head[b];
      if (!live(n)) return STAT_NO_SPACE;
      total = node_size[n];
      node_size[n] = want;
      node_used[n] = 1'b1;
      x = bin_next[n];
      bin_head[b] = x;
      if (live(x)) bin_prev[x] = NONE;
      free_bytes -= total;
      if (x == NONE) clear_bin(b);
      rem = total - want;
      if (rem > 0) begin
         m = bin_insert(rem, node_off[n] + want);
         if (live(m)) begin
            nx = addr_next[n];
            if (live(nx)) addr_prev[nx] = m;
            addr_prev[m] = n;
            addr_next[m] = nx;
            addr_next[n] = m;
         end
      end
      off = node_off[n];
      handle = n;
      return STAT_OK;
   endfunction

   function automatic status_type do_free(logic [10:0] h);
      logic [31:0] off, sz;
      logic [10:0] p, q, nn, np, c;
      if (!live(h) || !node_used[h]) return STAT_BAD_HANDLE;
      off = node_off[h];
      sz = node_size[h];
      p = addr_prev[h];
      if (live(p) && !node_used[p]) begin
         off = node_off[p];
         sz += node_size[p];
         bin_remove(p);
         addr_prev[h] = addr_prev[p];
      end
      q = addr_next[h];
      if (live(q) && !node_used[q]) begin
         sz += node_size[q];
         bin_remove(q);
         addr_next[h] = addr_next[q];
      end
      nn = addr_next[h];
      np = addr_prev[h];
      spare_push(h);
      c = bin_insert(sz, off);
      if (!live(c)) return STAT_OK;
      if (live(nn)) begin
         addr_next[c] = nn;
         addr_prev[nn] = c;
      end
      if (live(np)) begin
         addr_prev[c] = np;
         addr_next[np] = c;
      end
      return STAT_OK;
   endfunction

   function automatic rsp_type predict(req_type it);
      rsp_type r;
      int unsigned t;
      r = '0;
      case (it.func)
         FUNC_ALLOC:   r.status = do_alloc(it.request_size, r.block_offset, r.block_handle);
         FUNC_FREE:    r.status = do_free(it.release_handle);
         FUNC_RESTART: begin
            rebuild();
            r.status = STAT_OK;
         end
         default:      r.status = STAT_OK;
      endcase
      // the free total and largest class read as zero on the last spare node
      if (spare_top > 0) begin
         r.free_total = free_bytes;
         if (top_mask != 0) begin
            t = msb(top_mask);
            if (leaf_mask[t] != 0)
               r.largest_free = class_bytes((t << MANT_BITS) | msb(32'(leaf_mask[t])));
         end
      end
      return r;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         heap_bytes = HEAP_RESET;
         rebuild();
         expected_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected result", 32'(rsp_data.status), 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.block_offset !== want.block_offset)
                  report("block_offset", rsp_data.block_offset, want.block_offset);
               if (rsp_data.block_handle !== want.block_handle)
                  report("block_handle", 32'(rsp_data.block_handle), 32'(want.block_handle));
               if (rsp_data.free_total !== want.free_total)
                  report("free_total", rsp_data.free_total, want.free_total);
               if (rsp_data.largest_free !== want.largest_free)
                  report("largest_free", rsp_data.largest_free, want.largest_free);
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(predict(req_data));
         if (csr_we) heap_bytes = csr_wdata;
      end
   end

endmodule

/* verif/tb.sv */
// Testbench top for the two-level bin offset allocator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
   import tlboa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          errors;
   int          pending;

   bit          quiet;
   logic [31:0] heap_now;
   func_type    sent_funcs[$];
   logic [10:0] live_handles[$];
   int          stuck_cycles;

   two_level_bin_offset_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   alloc_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= quiet || ($urandom_range(99) >= 23);
   end

   // track returned handles so frees mostly hit live blocks
   always @(posedge clock) begin
      func_type f;
      if (!reset && rsp_valid && rsp_ready && sent_funcs.size() != 0) begin
         f = sent_funcs.pop_front();
         if (f == FUNC_ALLOC && rsp_data.status == STAT_OK)
            live_handles.push_back(rsp_data.block_handle);
         else if (f == FUNC_RESTART)
            live_handles.delete();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending == 0 && !req_valid))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic send(input func_type f, input logic [31:0] want, input logic [10:0] h);
      req_type it;
      it.func = f;
      it.request_size = want;
      it.release_handle = h;
      if (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      sent_funcs.push_back(f);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for every result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (48) @(posedge clock);
   endtask

   task automatic set_heap(input logic [31:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      heap_now = v;
      @(posedge clock);
      csr_we <= 1'b0;
      send(FUNC_RESTART, $urandom, $urandom);
   endtask

   task automatic free_live(input int idx);
      logic [10:0] h;
      h = live_handles[idx];
      live_handles.delete(idx);
      send(FUNC_FREE, $urandom, h);
   endtask

   function automatic logic [31:0] pick_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return 32'd0;
      if (r < 10) return $urandom;
      if (r < 40) return $urandom_range(1, 64);
      return $urandom_range(1, (heap_now >> 4) + 1);
   endfunction

   task automatic random_ops(input int count);
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 50) send(FUNC_ALLOC, pick_size(), $urandom);
         else if (r < 88 && live_handles.size() != 0)
            free_live($urandom_range(live_handles.size() - 1));
         else if (r < 94) send(FUNC_FREE, $urandom, 11'($urandom_range(2047)));
         else if (r < 97) send(FUNC_NOP, $urandom, $urandom);
         else send(FUNC_RESTART, $urandom, $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      quiet = 1'b0;
      heap_now = HEAP_RESET;
      stuck_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: size extremes, bad handles, nop, merges on both sides
      send(FUNC_ALLOC, 32'd0, 11'd0);
      send(FUNC_ALLOC, 32'd1, 11'd0);
      send(FUNC_ALLOC, 32'd7, 11'd0);
      send(FUNC_ALLOC, 32'd8, 11'd0);
      send(FUNC_ALLOC, 32'd9, 11'd0);
      send(FUNC_ALLOC, 32'hFFFF_FFFF, 11'd0);
      send(FUNC_FREE, 32'd0, 11'd1025);
      send(FUNC_FREE, 32'd0, 11'h7FF);
      send(FUNC_NOP, 32'hFFFF_FFFF, 11'h7FF);
      send(FUNC_RESTART, 32'd0, 11'd0);
      send(FUNC_ALLOC, 32'd100, 11'd0);
      send(FUNC_ALLOC, 32'd100, 11'd0);
      send(FUNC_ALLOC, 32'd100, 11'd0);
      drain();
      free_live(0);
      free_live(1);
      send(FUNC_FREE, 32'd0, 11'd0);
      free_live(0);
      send(FUNC_FREE, 32'd0, 11'd0);

      set_heap(32'd1);
      send(FUNC_ALLOC, 32'd1, 11'd0);
      send(FUNC_ALLOC, 32'd1, 11'd0);
      random_ops(60);

      set_heap(32'hFFFF_FFFF);
      send(FUNC_ALLOC, 32'hFFFF_FFFF, 11'd0);
      random_ops(150);

      // run the spare node stack down to its last entry
      set_heap(32'h1000_0000);
      quiet = 1'b1;
      for (int i = 0; i < 1030; i++) send(FUNC_ALLOC, $urandom_range(0, 64), 11'd0);
      quiet = 1'b0;
      drain();
      random_ops(80);

      set_heap(HEAP_RESET);
      random_ops(250);

      set_heap($urandom_range(100, 1 << 20));
      random_ops(200);

      set_heap($urandom);
      random_ops(150);

      drain();
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
